// ===== hdl/sclx_pkg.sv =====
package sclx_pkg;

  // one byte of the command line, or the end marker
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } sclx_in_t;

  // one result record
  typedef struct packed {
    logic [1:0] record_type;
    logic [7:0] buf_index;
    logic [7:0] buf_byte;
    logic [2:0] token_kind;
    logic [5:0] token_index;
    logic [7:0] token_start;
    logic [2:0] status;
    logic [6:0] token_count;
    logic       last;
  } sclx_out_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_GAP,
    PH_WORD,
    PH_QUOTE,
    PH_PIPE,
    PH_GT,
    PH_COMMENT,
    PH_ERROR
  } sclx_phase_t;

  localparam logic [1:0] REC_BYTE   = 2'd0;
  localparam logic [1:0] REC_TOKEN  = 2'd1;
  localparam logic [1:0] REC_STATUS = 2'd2;

  localparam logic [2:0] KIND_WORD   = 3'd0;
  localparam logic [2:0] KIND_PIPE   = 3'd1;
  localparam logic [2:0] KIND_IN     = 3'd2;
  localparam logic [2:0] KIND_OUT    = 3'd3;
  localparam logic [2:0] KIND_APPEND = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_TOO_MANY    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG    = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

endpackage

// ===== hdl/shell_command_line_lexer.sv =====
// datapath: an accepted transaction is held in the input register, then lexed into the
//   three-entry result queue once the queue is empty or drains its last record
// throughput: one byte per cycle while each byte yields at most one record and out_stall is low;
//   a byte yielding several records holds the next byte stalled while they drain
// reset: synchronous active-low rst_n returns the lexer to line start, with empty buffer,
//   no tokens, no pending error, and empties the input and result stages
module shell_command_line_lexer #(
  parameter int LINE_CAPACITY = 256,
  parameter int TOKEN_SLOTS   = 64,
  parameter int WORD_LIMIT    = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sclx_pkg::sclx_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sclx_pkg::sclx_out_t out_data
);
  import sclx_pkg::*;

  localparam int POS_W = $clog2(LINE_CAPACITY);
  localparam int WL_W  = $clog2(WORD_LIMIT + 1);
  localparam int TK_W  = $clog2(TOKEN_SLOTS + 1);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(LINE_CAPACITY - 1);
  localparam logic [WL_W-1:0]  WL_FULL   = WL_W'(WORD_LIMIT);
  localparam logic [TK_W-1:0]  TK_FULL   = TK_W'(TOKEN_SLOTS);

  // record builders, fields masked to their output widths
  function automatic sclx_out_t mk_byte(logic [POS_W-1:0] idx, logic [7:0] b);
    sclx_out_t r;
    r             = '0;
    r.record_type = REC_BYTE;
    r.buf_index   = 8'(idx);
    r.buf_byte    = b;
    return r;
  endfunction

  function automatic sclx_out_t mk_tok(logic [2:0] kind, logic [TK_W-1:0] idx,
                                       logic [POS_W-1:0] start);
    sclx_out_t r;
    r             = '0;
    r.record_type = REC_TOKEN;
    r.token_kind  = kind;
    r.token_index = 6'(idx);
    r.token_start = 8'(start);
    return r;
  endfunction

  function automatic sclx_out_t mk_stat(logic [2:0] st, logic [TK_W-1:0] cnt);
    sclx_out_t r;
    r             = '0;
    r.record_type = REC_STATUS;
    r.status      = st;
    r.token_count = 7'(cnt);
    return r;
  endfunction

  // input stage
  logic      inv_r;
  sclx_in_t  in_r;

  // line state
  sclx_phase_t      phase_r;
  logic [POS_W-1:0] bpos_r;
  logic [WL_W-1:0]  wlen_r;
  logic [POS_W-1:0] wstart_r;
  logic [TK_W-1:0]  tok_r;
  logic [2:0]       err_r;

  // result queue, head at entry 0
  sclx_out_t  q_r [3];
  logic [1:0] qcnt_r;

  // next-state values from the single pass
  sclx_phase_t      phase_nxt;
  logic [POS_W-1:0] bpos_nxt;
  logic [WL_W-1:0]  wlen_nxt;
  logic [POS_W-1:0] wstart_nxt;
  logic [TK_W-1:0]  tok_nxt;
  logic [2:0]       err_nxt;
  sclx_out_t        res [3];
  logic [1:0]       res_n;

  logic out_take;
  logic q_free;
  logic proc;
  logic in_take;

  // handshake: the held byte is lexed once the queue empties, or drains its last entry
  assign out_valid = (qcnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign out_take  = out_valid && !out_stall;
  assign q_free    = (qcnt_r == 2'd0) || ((qcnt_r == 2'd1) && out_take);
  assign proc      = inv_r && q_free;
  assign in_stall  = inv_r && !q_free;
  assign in_take   = in_valid && !in_stall;

  // one pass of the lexer over the held transaction
  always_comb begin
    logic [7:0] c;
    logic       is_sep;
    logic       is_rej;
    logic       fin;
    logic       psh;
    logic [2:0] pkind;
    logic       gap;
    logic       disp;
    logic       wb;
    logic       wchk;
    logic       f2;
    logic [2:0] st;

    c          = in_r.ch;
    is_sep     = (c inside {CH_SPACE, CH_TAB});
    is_rej     = (c inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_STAR, CH_QMARK,
                            CH_LBRACK, CH_RBRACK, CH_SEMI, CH_AMP});
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    wlen_nxt   = wlen_r;
    wstart_nxt = wstart_r;
    tok_nxt    = tok_r;
    err_nxt    = err_r;
    res[0]     = '0;
    res[1]     = '0;
    res[2]     = '0;
    res_n      = 2'd0;
    fin        = 1'b0;
    psh        = 1'b0;
    pkind      = KIND_WORD;
    gap        = 1'b0;
    disp       = 1'b0;
    wb         = 1'b0;
    wchk       = 1'b0;
    f2         = 1'b0;
    st         = ST_OK;

    // what the current phase does with this byte or with the end marker
    if (in_r.is_end) begin
      case (phase_r)
        PH_WORD:  fin = 1'b1;
        PH_QUOTE: f2 = 1'b1;
        PH_PIPE: begin
          psh   = 1'b1;
          pkind = KIND_PIPE;
        end
        PH_GT: begin
          psh   = 1'b1;
          pkind = KIND_OUT;
        end
        default: ;
      endcase
    end else if (c != CH_NUL) begin
      case (phase_r)
        PH_START, PH_GAP: disp = 1'b1;
        PH_WORD: begin
          if (is_sep || (c inside {CH_PIPE, CH_LT, CH_GT, CH_QUOTE})) begin
            fin  = 1'b1;
            gap  = 1'b1;
            disp = 1'b1;
          end else begin
            wb   = 1'b1;
            wchk = 1'b1;
          end
        end
        PH_QUOTE: begin
          if (c == CH_QUOTE) begin
            fin = 1'b1;
            gap = 1'b1;
          end else begin
            wb = 1'b1;
          end
        end
        PH_PIPE: begin
          if (c == CH_PIPE) begin
            f2 = 1'b1;
          end else begin
            psh   = 1'b1;
            pkind = KIND_PIPE;
            gap   = 1'b1;
            disp  = 1'b1;
          end
        end
        PH_GT: begin
          psh  = 1'b1;
          gap  = 1'b1;
          if (c == CH_GT) begin
            pkind = KIND_APPEND;
          end else begin
            pkind = KIND_OUT;
            disp  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // '||' and an unclosed quote
    if (f2) begin
      phase_nxt = PH_ERROR;
      err_nxt   = ST_UNSUPPORTED;
    end

    // close a word with its terminator
    if (fin) begin
      if (bpos_nxt == POS_LAST) begin
        phase_nxt = PH_ERROR;
        err_nxt   = ST_TOO_LONG;
      end else begin
        res[res_n] = mk_byte(bpos_nxt, CH_NUL);
        res_n      = res_n + 2'd1;
        bpos_nxt   = bpos_nxt + POS_W'(1);
      end
    end

    // word record after the terminator, or a pending operator record
    if ((fin || psh) && (phase_nxt != PH_ERROR)) begin
      if (tok_nxt == TK_FULL) begin
        phase_nxt = PH_ERROR;
        err_nxt   = ST_TOO_MANY;
      end else begin
        res[res_n] = mk_tok(fin ? KIND_WORD : pkind, tok_nxt,
                            fin ? wstart_nxt : '0);
        res_n      = res_n + 2'd1;
        tok_nxt    = tok_nxt + TK_W'(1);
      end
    end

    if (gap && (phase_nxt != PH_ERROR)) phase_nxt = PH_GAP;

    // byte at a point where a new token may begin
    if (disp && (phase_nxt != PH_ERROR) && !is_sep) begin
      if ((phase_nxt == PH_START) && (c == CH_HASH)) begin
        phase_nxt = PH_COMMENT;
      end else if (c == CH_PIPE) begin
        phase_nxt = PH_PIPE;
      end else if (c == CH_GT) begin
        phase_nxt = PH_GT;
      end else if (c == CH_LT) begin
        if (tok_nxt == TK_FULL) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_TOO_MANY;
        end else begin
          res[res_n] = mk_tok(KIND_IN, tok_nxt, '0);
          res_n      = res_n + 2'd1;
          tok_nxt    = tok_nxt + TK_W'(1);
          phase_nxt  = PH_GAP;
        end
      end else begin
        wstart_nxt = bpos_nxt;
        wlen_nxt   = '0;
        if (c == CH_QUOTE) begin
          phase_nxt = PH_QUOTE;
        end else begin
          phase_nxt = PH_WORD;
          wb        = 1'b1;
          wchk      = 1'b1;
        end
      end
    end

    // store one word byte, quoted bytes skip the rejected-set check
    if (wb && (phase_nxt != PH_ERROR)) begin
      if (wchk && is_rej) begin
        phase_nxt = PH_ERROR;
        err_nxt   = ST_UNSUPPORTED;
      end else if ((bpos_nxt == POS_LAST) || (wlen_nxt == WL_FULL)) begin
        phase_nxt = PH_ERROR;
        err_nxt   = ST_TOO_LONG;
      end else begin
        res[res_n] = mk_byte(bpos_nxt, c);
        res_n      = res_n + 2'd1;
        bpos_nxt   = bpos_nxt + POS_W'(1);
        wlen_nxt   = wlen_nxt + WL_W'(1);
      end
    end

    // end of line: report status, then back to line start
    if (in_r.is_end) begin
      if (phase_nxt == PH_ERROR) begin
        st = err_nxt;
      end else if (phase_nxt == PH_COMMENT) begin
        st = ST_EMPTY;
      end else begin
        st = (tok_nxt != '0) ? ST_OK : ST_EMPTY;
      end
      res[res_n] = mk_stat(st, (phase_nxt == PH_COMMENT) ? '0 : tok_nxt);
      res_n      = res_n + 2'd1;
      phase_nxt  = PH_START;
      bpos_nxt   = '0;
      wlen_nxt   = '0;
      wstart_nxt = '0;
      tok_nxt    = '0;
      err_nxt    = ST_OK;
    end

    // mark the final record of this transaction
    for (int i = 0; i < 3; i++) begin
      if ((res_n != 2'd0) && (2'(i) == (res_n - 2'd1))) res[i].last = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_take) begin
      inv_r <= 1'b1;
    end else if (proc) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_r <= in_data;
  end

  // line state, updated once per lexed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      bpos_r   <= '0;
      wlen_r   <= '0;
      wstart_r <= '0;
      tok_r    <= '0;
      err_r    <= ST_OK;
    end else if (proc) begin
      phase_r  <= phase_nxt;
      bpos_r   <= bpos_nxt;
      wlen_r   <= wlen_nxt;
      wstart_r <= wstart_nxt;
      tok_r    <= tok_nxt;
      err_r    <= err_nxt;
    end
  end

  // result queue: loaded whole, shifted toward the head as records leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= 2'd0;
    end else if (proc) begin
      qcnt_r <= res_n;
    end else if (out_take) begin
      qcnt_r <= qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      q_r[0] <= res[0];
      q_r[1] <= res[1];
      q_r[2] <= res[2];
    end else if (out_take) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

`ifndef SYNTHESIS
  a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (qcnt_r != 2'd0) |-> (q_r[0].last == (qcnt_r == 2'd1)))
    else $error("last flag does not mark the final queued record");

  a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r <= TK_FULL)
    else $error("token count beyond slot limit");

  a_wlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= WL_FULL)
    else $error("word length beyond limit");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bpos_r <= POS_LAST)
    else $error("buffer position beyond capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_r.is_end) |=> ((phase_r == PH_START) && (tok_r == '0) && (bpos_r == '0)))
    else $error("end of line did not return to line start");
`endif

endmodule
